@@ hw/rtl/tcbskt_pkg.sv @@
// Shared constants, codes and the pipeline item type of the TCB key tangent unit.
package tcbskt_pkg;

  // Field widths of the item.
  localparam int unsigned POS_BITS   = 32;
  localparam int unsigned FRAME_BITS = 16;
  localparam int unsigned PAR_BITS   = 16;

  // Quotient bits of the spacing divider (Q31 frame fraction).
  localparam int unsigned QB   = 31;
  localparam int unsigned NUMW = FRAME_BITS + QB;

  // Widths of the internal arithmetic.
  localparam int unsigned FW = PAR_BITS + 1;   // 1 +/- x factors
  localparam int unsigned DW = POS_BITS + 1;   // position differences
  localparam int unsigned WW = 39;             // Q30 weights
  localparam int unsigned WL = 20;             // low part of a split weight
  localparam int unsigned SW = WW + DW;        // exact weighted sums
  localparam int unsigned VW = SW - 30;        // sums back in Q16.16

  localparam logic signed [FW-1:0] Q14_ONE = FW'(16384);

  localparam logic signed [POS_BITS-1:0] POS_MAX = {1'b0, {(POS_BITS-1){1'b1}}};
  localparam logic signed [POS_BITS-1:0] POS_MIN = {1'b1, {(POS_BITS-1){1'b0}}};

  // Mode codes.
  localparam logic [1:0] MODE_FIRST = 2'd1;
  localparam logic [1:0] MODE_LAST  = 2'd2;

  // Status codes.
  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_SAT   = 2'd1;
  localparam logic [1:0] STATUS_ORDER = 2'd2;

  // Pipeline stage numbering.
  localparam int unsigned ST_DEC  = 0;
  localparam int unsigned ST_TC2  = 1;
  localparam int unsigned ST_TC3  = 2;
  localparam int unsigned ST_TCR  = 3;
  localparam int unsigned ST_DIV0 = 4;
  localparam int unsigned ST_SPM  = ST_DIV0 + QB;
  localparam int unsigned ST_SPR  = ST_SPM + 1;
  localparam int unsigned ST_KWM  = ST_SPR + 1;
  localparam int unsigned ST_KWR  = ST_KWM + 1;
  localparam int unsigned ST_PPM  = ST_KWR + 1;
  localparam int unsigned ST_PPS  = ST_PPM + 1;
  localparam int unsigned ST_SUM  = ST_PPS + 1;
  localparam int unsigned NDATA   = ST_SUM + 1;
  localparam int unsigned NST     = NDATA + 1;

  // Everything one item carries down the pipeline.
  typedef struct packed {
    logic                       err;
    logic                       m_first;
    logic                       m_last;
    logic signed [FW-1:0]       tmr;
    logic signed [FW-1:0]       cmr;
    logic signed [FW-1:0]       cpr;
    logic signed [FW-1:0]       bmr;
    logic signed [FW-1:0]       bpr;
    logic [PAR_BITS-1:0]        ac;
    logic signed [FW-1:0]       kac;
    logic [FRAME_BITS-1:0]      dt;
    logic [NUMW-1:0]            num;
    logic [FRAME_BITS-1:0]      rem;
    logic [QB-1:0]              quo;
    logic signed [DW-1:0]       d1;
    logic signed [DW-1:0]       d2;
    logic signed [2*FW-1:0]     pm;
    logic signed [2*FW-1:0]     pp;
    logic signed [3*FW-1:0]     tsm;
    logic signed [3*FW-1:0]     tsp;
    logic signed [3*FW-1:0]     tdm;
    logic signed [3*FW-1:0]     tdp;
    logic signed [29:0]         csm;
    logic signed [29:0]         csp;
    logic signed [29:0]         cdm;
    logic signed [29:0]         cdp;
    logic signed [48:0]         prod_p;
    logic signed [48:0]         prod_n;
    logic signed [33:0]         spp;
    logic signed [33:0]         spn;
    logic signed [WW-1:0]       w20;
    logic signed [63:0]         ksm;
    logic signed [63:0]         ksp;
    logic signed [63:0]         kdm;
    logic signed [63:0]         kdp;
    logic signed [WW-1:0]       wa1;
    logic signed [WW-1:0]       wa2;
    logic signed [WW-1:0]       wd1;
    logic signed [WW-1:0]       wd2;
    logic signed [SW-1:0]       pla1;
    logic signed [SW-1:0]       pha1;
    logic signed [SW-1:0]       pla2;
    logic signed [SW-1:0]       pha2;
    logic signed [SW-1:0]       pld1;
    logic signed [SW-1:0]       phd1;
    logic signed [SW-1:0]       pld2;
    logic signed [SW-1:0]       phd2;
    logic signed [SW-1:0]       ta1;
    logic signed [SW-1:0]       ta2;
    logic signed [SW-1:0]       td1;
    logic signed [SW-1:0]       td2;
    logic signed [SW-1:0]       sa;
    logic signed [SW-1:0]       sd;
  } pipe_t;

endpackage

@@ hw/rtl/tcb_spline_key_tangents_unit.sv @@
// TCB spline key tangent unit: pipelined datapath from three keys to two slopes.
// Throughput: one item per cycle unless out_ready_i stalls the output; the frame spacing
// divider resolves one quotient bit per stage over 31 stages, which sets the depth.
// Each stage moves on when it is empty or its successor moves, so a stall loses nothing.
// Reset clears only the stage valid bits; payload registers are not reset.
module tcb_spline_key_tangents_unit
  import tcbskt_pkg::*;
(
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [1:0]                 mode_i,
  input  logic [FRAME_BITS-1:0]      frame_a_i,
  input  logic [FRAME_BITS-1:0]      frame_b_i,
  input  logic [FRAME_BITS-1:0]      frame_c_i,
  input  logic signed [POS_BITS-1:0] pos_a_i,
  input  logic signed [POS_BITS-1:0] pos_b_i,
  input  logic signed [POS_BITS-1:0] pos_c_i,
  input  logic signed [PAR_BITS-1:0] tension_i,
  input  logic signed [PAR_BITS-1:0] continuity_i,
  input  logic signed [PAR_BITS-1:0] bias_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic signed [POS_BITS-1:0] arriving_slope_o,
  output logic signed [POS_BITS-1:0] departing_slope_o,
  output logic [1:0]                 status_o
);

  // Round a triple factor product to Q24, ties away from zero.
  function automatic logic signed [29:0] rnd19(input logic signed [3*FW-1:0] x);
    logic signed [3*FW-1:0] y;
    y = x + (x[3*FW-1] ? (3*FW)'(262143) : (3*FW)'(262144));
    return 30'(y >>> 19);
  endfunction

  // Round a weight product to Q30, ties away from zero.
  function automatic logic signed [WW-1:0] rnd24(input logic signed [63:0] x);
    logic signed [63:0] y;
    y = x + (x[63] ? 64'sd8388607 : 64'sd8388608);
    return WW'(y >>> 24);
  endfunction

  // Saturate a rounded sum to the position width.
  function automatic logic signed [POS_BITS-1:0] sat_pos(input logic signed [SW-1:0] s,
                                                         output logic ovf);
    logic signed [VW-1:0]      v;
    logic [VW-POS_BITS:0]      hi;
    v   = VW'(s >>> 30);
    hi  = v[VW-1:POS_BITS-1];
    ovf = !((&hi) || (~|hi));
    if (ovf) begin
      return v[VW-1] ? POS_MIN : POS_MAX;
    end
    return v[POS_BITS-1:0];
  endfunction

  pipe_t            data_q [NDATA];
  pipe_t            data_d [NDATA];
  logic [NST-1:0]   v_q;
  logic [NST-1:0]   en;

  logic signed [POS_BITS-1:0] arr_q, arr_d;
  logic signed [POS_BITS-1:0] dep_q, dep_d;
  logic [1:0]                 status_q, status_d;

  // Stage enables: a stage loads when it is empty or its successor loads.
  always_comb begin
    en[NST-1] = !v_q[NST-1] || out_ready_i;
    for (int k = NST - 2; k >= 0; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
  end

  assign in_ready_o  = en[0];
  assign out_valid_o = v_q[NST-1];

  // Decode the item: order check, 1 +/- x factors, divider operands, differences.
  always_comb begin : c_dec
    pipe_t                 s;
    logic [PAR_BITS-1:0]   ac;
    logic [FRAME_BITS-1:0] f10;
    logic                  interior;
    s          = '0;
    s.err      = !((frame_a_i < frame_b_i) && (frame_b_i < frame_c_i));
    s.m_first  = (mode_i == MODE_FIRST);
    s.m_last   = (mode_i == MODE_LAST);
    interior   = !s.m_first && !s.m_last;
    s.tmr      = Q14_ONE - FW'(tension_i);
    s.cmr      = Q14_ONE - FW'(continuity_i);
    s.cpr      = Q14_ONE + FW'(continuity_i);
    s.bmr      = Q14_ONE - FW'(bias_i);
    s.bpr      = Q14_ONE + FW'(bias_i);
    ac         = continuity_i[PAR_BITS-1] ? PAR_BITS'(~$unsigned(continuity_i) + 1'b1)
                                          : $unsigned(continuity_i);
    s.ac       = ac;
    s.kac      = Q14_ONE - $signed({1'b0, ac});
    s.dt       = frame_c_i - frame_a_i;
    f10        = s.m_last ? (frame_c_i - frame_b_i) : (frame_b_i - frame_a_i);
    if (interior) begin
      s.num = (NUMW'(f10) << QB) + NUMW'(s.dt >> 1);
    end else begin
      s.num = (NUMW'(f10) << (QB - 2)) + NUMW'(s.dt >> 1);
    end
    s.d1 = s.m_last ? (DW'(pos_c_i) - DW'(pos_b_i)) : (DW'(pos_b_i) - DW'(pos_a_i));
    s.d2 = interior ? (DW'(pos_c_i) - DW'(pos_b_i)) : (DW'(pos_c_i) - DW'(pos_a_i));
    data_d[ST_DEC] = s;
  end

  // Tension times continuity factors.
  always_comb begin : c_tc2
    pipe_t s;
    s    = data_q[ST_DEC];
    s.pm = (2*FW)'(s.tmr) * (2*FW)'(s.cmr);
    s.pp = (2*FW)'(s.tmr) * (2*FW)'(s.cpr);
    data_d[ST_TC2] = s;
  end

  // Times the bias factors: the four published TCB weights.
  always_comb begin : c_tc3
    pipe_t s;
    s     = data_q[ST_TC2];
    s.tsm = (3*FW)'(s.pm) * (3*FW)'(s.bpr);
    s.tsp = (3*FW)'(s.pp) * (3*FW)'(s.bmr);
    s.tdm = (3*FW)'(s.pp) * (3*FW)'(s.bpr);
    s.tdp = (3*FW)'(s.pm) * (3*FW)'(s.bmr);
    data_d[ST_TC3] = s;
  end

  // Round the TCB weights to Q24.
  always_comb begin : c_tcr
    pipe_t s;
    s     = data_q[ST_TC3];
    s.csm = rnd19(s.tsm);
    s.csp = rnd19(s.tsp);
    s.cdm = rnd19(s.tdm);
    s.cdp = rnd19(s.tdp);
    data_d[ST_TCR] = s;
  end

  // Restoring divider for the frame ratio, one quotient bit per stage.
  for (genvar gi = 0; gi < QB; gi++) begin : g_div
    always_comb begin : c_div
      pipe_t                 s;
      logic [FRAME_BITS-1:0] r;
      logic [FRAME_BITS:0]   tr;
      logic                  ge;
      s  = data_q[ST_DIV0+gi-1];
      r  = (gi == 0) ? s.num[NUMW-1 -: FRAME_BITS] : s.rem;
      tr = {r, s.num[QB-1-gi]};
      ge = (tr >= {1'b0, s.dt});
      s.rem = ge ? FRAME_BITS'(tr - {1'b0, s.dt}) : FRAME_BITS'(tr);
      s.quo[QB-1-gi] = ge;
      data_d[ST_DIV0+gi] = s;
    end
  end

  // Spacing products; in the end-key modes the first one is (1 - tension) times ratio.
  always_comb begin : c_spm
    pipe_t                s;
    logic [31:0]          fn;
    logic signed [FW-1:0] mul_a;
    s        = data_q[ST_SPM-1];
    fn       = 32'h8000_0000 - {1'b0, s.quo};
    mul_a    = (!s.m_first && !s.m_last) ? s.kac : s.tmr;
    s.prod_p = 49'($signed({2'b0, s.quo})) * 49'(mul_a);
    s.prod_n = 49'($signed({1'b0, fn})) * 49'(s.kac);
    data_d[ST_SPM] = s;
  end

  // Continuity-adjusted spacings and the ratio weight of the end-key modes.
  always_comb begin : c_spr
    pipe_t              s;
    logic signed [48:0] acs;
    logic signed [48:0] sum_p;
    logic signed [48:0] sum_n;
    logic signed [48:0] rp;
    s     = data_q[ST_SPM];
    acs   = $signed({33'b0, s.ac}) <<< 30;
    sum_p = s.prod_p + acs + 49'sd8192;
    sum_n = s.prod_n + acs + 49'sd8192;
    s.spp = 34'(sum_p >>> 14);
    s.spn = 34'(sum_n >>> 14);
    rp    = s.prod_p + (s.prod_p[48] ? 49'sd8191 : 49'sd8192);
    s.w20 = -(WW'(rp >>> 14));
    data_d[ST_SPR] = s;
  end

  // TCB weights times spacings.
  always_comb begin : c_kwm
    pipe_t s;
    s     = data_q[ST_SPR];
    s.ksm = 64'(s.csm) * 64'(s.spp);
    s.ksp = 64'(s.csp) * 64'(s.spp);
    s.kdm = 64'(s.cdm) * 64'(s.spn);
    s.kdp = 64'(s.cdp) * 64'(s.spn);
    data_d[ST_KWM] = s;
  end

  // Final Q30 weights per mode; the unused slope gets zero weights.
  always_comb begin : c_kwr
    pipe_t                s;
    logic signed [WW-1:0] w10;
    s   = data_q[ST_KWM];
    w10 = (WW'(s.tmr) <<< 16) + (WW'(s.tmr) <<< 15);
    if (s.m_first) begin
      s.wa1 = '0;
      s.wa2 = '0;
      s.wd1 = w10;
      s.wd2 = s.w20;
    end else if (s.m_last) begin
      s.wa1 = w10;
      s.wa2 = s.w20;
      s.wd1 = '0;
      s.wd2 = '0;
    end else begin
      s.wa1 = rnd24(s.ksm);
      s.wa2 = rnd24(s.ksp);
      s.wd1 = rnd24(s.kdm);
      s.wd2 = rnd24(s.kdp);
    end
    data_d[ST_KWR] = s;
  end

  // Partial products of weight halves and differences.
  always_comb begin : c_ppm
    pipe_t s;
    s      = data_q[ST_KWR];
    s.pla1 = SW'($signed({1'b0, s.wa1[WL-1:0]})) * SW'(s.d1);
    s.pha1 = SW'($signed(s.wa1[WW-1:WL])) * SW'(s.d1);
    s.pla2 = SW'($signed({1'b0, s.wa2[WL-1:0]})) * SW'(s.d2);
    s.pha2 = SW'($signed(s.wa2[WW-1:WL])) * SW'(s.d2);
    s.pld1 = SW'($signed({1'b0, s.wd1[WL-1:0]})) * SW'(s.d1);
    s.phd1 = SW'($signed(s.wd1[WW-1:WL])) * SW'(s.d1);
    s.pld2 = SW'($signed({1'b0, s.wd2[WL-1:0]})) * SW'(s.d2);
    s.phd2 = SW'($signed(s.wd2[WW-1:WL])) * SW'(s.d2);
    data_d[ST_PPM] = s;
  end

  // Join the partial products of each term.
  always_comb begin : c_pps
    pipe_t s;
    s     = data_q[ST_PPM];
    s.ta1 = (s.pha1 <<< WL) + s.pla1;
    s.ta2 = (s.pha2 <<< WL) + s.pla2;
    s.td1 = (s.phd1 <<< WL) + s.pld1;
    s.td2 = (s.phd2 <<< WL) + s.pld2;
    data_d[ST_PPS] = s;
  end

  // Sum both terms with the rounding half.
  always_comb begin : c_sum
    pipe_t s;
    s    = data_q[ST_PPS];
    s.sa = s.ta1 + s.ta2 + SW'(64'd536870912);
    s.sd = s.td1 + s.td2 + SW'(64'd536870912);
    data_d[ST_SUM] = s;
  end

  // Shift to Q16.16, saturate and set the status.
  always_comb begin : c_out
    pipe_t                      s;
    logic                       ova;
    logic                       ovd;
    logic signed [POS_BITS-1:0] va;
    logic signed [POS_BITS-1:0] vd;
    s  = data_q[ST_SUM];
    va = sat_pos(s.sa, ova);
    vd = sat_pos(s.sd, ovd);
    if (s.err) begin
      arr_d    = '0;
      dep_d    = '0;
      status_d = STATUS_ORDER;
    end else begin
      arr_d    = va;
      dep_d    = vd;
      status_d = (ova || ovd) ? STATUS_SAT : STATUS_OK;
    end
  end

  // Stage valid bits.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) begin
        v_q[0] <= in_valid_i;
      end
      for (int k = 1; k < NST; k++) begin
        if (en[k]) begin
          v_q[k] <= v_q[k-1];
        end
      end
    end
  end

  // Stage payload registers.
  always_ff @(posedge clk_i) begin
    for (int k = 0; k < NDATA; k++) begin
      if (en[k]) begin
        data_q[k] <= data_d[k];
      end
    end
    if (en[NST-1]) begin
      arr_q    <= arr_d;
      dep_q    <= dep_d;
      status_q <= status_d;
    end
  end

  assign arriving_slope_o  = arr_q;
  assign departing_slope_o = dep_q;
  assign status_o          = status_q;

endmodule

@@ hw/rtl/tcbskt_checker.sv @@
// Port-level checker for the TCB key tangent unit, bound to the top level.
module tcbskt_checker
  import tcbskt_pkg::*;
(
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       in_valid_i,
  input logic                       in_ready_o,
  input logic [1:0]                 mode_i,
  input logic [FRAME_BITS-1:0]      frame_a_i,
  input logic [FRAME_BITS-1:0]      frame_b_i,
  input logic [FRAME_BITS-1:0]      frame_c_i,
  input logic signed [POS_BITS-1:0] pos_a_i,
  input logic signed [POS_BITS-1:0] pos_b_i,
  input logic signed [POS_BITS-1:0] pos_c_i,
  input logic signed [PAR_BITS-1:0] tension_i,
  input logic signed [PAR_BITS-1:0] continuity_i,
  input logic signed [PAR_BITS-1:0] bias_i,
  input logic                       out_valid_o,
  input logic                       out_ready_i,
  input logic signed [POS_BITS-1:0] arriving_slope_o,
  input logic signed [POS_BITS-1:0] departing_slope_o,
  input logic [1:0]                 status_o
);

  // A result item held back keeps its value.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(arriving_slope_o)
      && $stable(departing_slope_o) && $stable(status_o))
    else $error("result item changed while stalled");

  // When the output is free or draining, the pipeline takes a new item.
  a_ready_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!out_valid_o || out_ready_i) |-> in_ready_o)
    else $error("input stalled although output is free");

  // Frames out of order give zero slopes.
  a_order_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == STATUS_ORDER) |->
      (arriving_slope_o == '0) && (departing_slope_o == '0))
    else $error("non-zero slope with frame order error");

  // A saturated result shows a clipped slope.
  a_sat_clip: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == STATUS_SAT) |->
      (arriving_slope_o == POS_MAX) || (arriving_slope_o == POS_MIN) ||
      (departing_slope_o == POS_MAX) || (departing_slope_o == POS_MIN))
    else $error("saturation flagged without a clipped slope");

endmodule

bind tcb_spline_key_tangents_unit tcbskt_checker u_tcbskt_checker (.*);

@@ bench/tcb_spline_key_tangents_unit_tb.sv @@
// Self-checking testbench of the TCB spline key tangent unit.
module tcb_spline_key_tangents_unit_tb;
  import tcbskt_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // Modes that the package leaves unnamed.
  localparam logic [1:0] MODE_INTERIOR = 2'd0;
  localparam logic [1:0] MODE_SPARE    = 2'd3;

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned DRAIN_CYCLES = 60;

  typedef struct {
    logic [1:0]                 mode;
    logic [FRAME_BITS-1:0]      fa;
    logic [FRAME_BITS-1:0]      fb;
    logic [FRAME_BITS-1:0]      fc;
    logic signed [POS_BITS-1:0] pa;
    logic signed [POS_BITS-1:0] pb;
    logic signed [POS_BITS-1:0] pc;
    logic signed [PAR_BITS-1:0] t;
    logic signed [PAR_BITS-1:0] c;
    logic signed [PAR_BITS-1:0] b;
  } key_item_t;

  typedef struct {
    logic signed [POS_BITS-1:0] arr;
    logic signed [POS_BITS-1:0] dep;
    logic [1:0]                 st;
  } slope_item_t;

  logic                       clk_i = 1'b0;
  logic                       rst_ni = 1'b0;
  logic                       in_valid_i = 1'b0;
  logic                       in_ready_o;
  logic [1:0]                 mode_i = '0;
  logic [FRAME_BITS-1:0]      frame_a_i = '0;
  logic [FRAME_BITS-1:0]      frame_b_i = '0;
  logic [FRAME_BITS-1:0]      frame_c_i = '0;
  logic signed [POS_BITS-1:0] pos_a_i = '0;
  logic signed [POS_BITS-1:0] pos_b_i = '0;
  logic signed [POS_BITS-1:0] pos_c_i = '0;
  logic signed [PAR_BITS-1:0] tension_i = '0;
  logic signed [PAR_BITS-1:0] continuity_i = '0;
  logic signed [PAR_BITS-1:0] bias_i = '0;
  logic                       out_valid_o;
  logic                       out_ready_i = 1'b0;
  logic signed [POS_BITS-1:0] arriving_slope_o;
  logic signed [POS_BITS-1:0] departing_slope_o;
  logic [1:0]                 status_o;

  slope_item_t pending_slopes[$];
  int unsigned errors = 0;
  int unsigned sent_items = 0;
  int unsigned checked_items = 0;
  int unsigned cycle_count = 0;
  int unsigned burst_left = 0;
  bit          sender_idles = 1'b1;
  bit          receiver_stalls = 1'b1;

  tcb_spline_key_tangents_unit uut (.*);

  always #5 clk_i = ~clk_i;

  // Rounding right shift with ties away from zero.
  function automatic logic signed [127:0] round_shr(logic signed [127:0] x, int s);
    logic signed [127:0] mag;
    mag = (x < 0) ? -x : x;
    mag = (mag + (128'sd1 <<< (s - 1))) >>> s;
    return (x < 0) ? -mag : mag;
  endfunction

  // Exact weighted sum, rounded back to Q16.16 and clipped.
  function automatic logic signed [POS_BITS-1:0] weighted_slope(
      logic signed [127:0] w1, logic signed [127:0] d1,
      logic signed [127:0] w2, logic signed [127:0] d2, inout bit sat);
    logic signed [127:0] v;
    v = (w1 * d1 + w2 * d2 + (128'sd1 <<< 29)) >>> 30;
    if (v > 128'sd2147483647) begin
      sat = 1'b1;
      return POS_MAX;
    end
    if (v < -128'sd2147483648) begin
      sat = 1'b1;
      return POS_MIN;
    end
    return v[POS_BITS-1:0];
  endfunction

  // Interior weight: TCB product in Q24 times spacing in Q30.
  function automatic logic signed [127:0] interior_weight(
      logic signed [127:0] f1, logic signed [127:0] f2,
      logic signed [127:0] f3, logic signed [127:0] sp);
    return round_shr(round_shr(f1 * f2 * f3, 19) * sp, 24);
  endfunction

  function automatic slope_item_t predict_tangents(key_item_t k);
    slope_item_t res;
    logic [63:0] fa, fb, fc, f10, f20, ratio, fracp;
    logic signed [127:0] pa, pb, pc, t, c, b, tmr, w10, w20, rr;
    logic signed [127:0] fp, fn, ac, spp, spn, cmr, cpr, bmr, bpr;
    bit sat;
    fa = 64'(k.fa); fb = 64'(k.fb); fc = 64'(k.fc);
    pa = 128'(k.pa); pb = 128'(k.pb); pc = 128'(k.pc);
    t = 128'(k.t); c = 128'(k.c); b = 128'(k.b);
    tmr = 128'sd16384 - t;
    sat = 1'b0;
    res.arr = '0;
    res.dep = '0;
    res.st = STATUS_OK;
    if (!(fa < fb && fb < fc)) begin
      res.st = STATUS_ORDER;
    end else if (k.mode == MODE_FIRST || k.mode == MODE_LAST) begin
      f20 = fc - fa;
      f10 = (k.mode == MODE_FIRST) ? fb - fa : fc - fb;
      ratio = ((f10 << 29) + f20 / 2) / f20;
      rr = $signed({64'd0, ratio});
      w10 = tmr * 3 * 32768;
      w20 = -round_shr(tmr * rr, 14);
      if (k.mode == MODE_FIRST)
        res.dep = weighted_slope(w10, pb - pa, w20, pc - pa, sat);
      else
        res.arr = weighted_slope(w10, pc - pb, w20, pc - pa, sat);
    end else begin
      f20 = fc - fa;
      fracp = (((fb - fa) << 31) + f20 / 2) / f20;
      fp = $signed({64'd0, fracp});
      fn = (128'sd1 <<< 31) - fp;
      ac = (c < 0) ? -c : c;
      spp = round_shr(fp * (128'sd16384 - ac) + ac * (128'sd1 <<< 30), 14);
      spn = round_shr(fn * (128'sd16384 - ac) + ac * (128'sd1 <<< 30), 14);
      cmr = 128'sd16384 - c; cpr = 128'sd16384 + c;
      bmr = 128'sd16384 - b; bpr = 128'sd16384 + b;
      res.arr = weighted_slope(interior_weight(tmr, cmr, bpr, spp), pb - pa,
                               interior_weight(tmr, cpr, bmr, spp), pc - pb, sat);
      res.dep = weighted_slope(interior_weight(tmr, cpr, bpr, spn), pb - pa,
                               interior_weight(tmr, cmr, bmr, spn), pc - pb, sat);
    end
    if (res.st == STATUS_OK && sat)
      res.st = STATUS_SAT;
    return res;
  endfunction

  // Present one item, wait for acceptance, then idle a random gap after a burst.
  task automatic send_key(key_item_t k);
    int unsigned gap;
    in_valid_i   <= 1'b1;
    mode_i       <= k.mode;
    frame_a_i    <= k.fa;
    frame_b_i    <= k.fb;
    frame_c_i    <= k.fc;
    pos_a_i      <= k.pa;
    pos_b_i      <= k.pb;
    pos_c_i      <= k.pc;
    tension_i    <= k.t;
    continuity_i <= k.c;
    bias_i       <= k.b;
    do @(posedge clk_i); while (!in_ready_o);
    pending_slopes.push_back(predict_tangents(k));
    sent_items++;
    gap = 0;
    if (sender_idles) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 30);
        gap = $urandom_range(1, 12);
      end else begin
        burst_left--;
      end
    end
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  function automatic key_item_t make_key(logic [1:0] m, int fa, int fb, int fc,
      logic signed [31:0] pa, logic signed [31:0] pb, logic signed [31:0] pc,
      logic signed [15:0] t, logic signed [15:0] c, logic signed [15:0] b);
    key_item_t k;
    k.mode = m;
    k.fa = FRAME_BITS'(fa); k.fb = FRAME_BITS'(fb); k.fc = FRAME_BITS'(fc);
    k.pa = pa; k.pb = pb; k.pc = pc;
    k.t = t; k.c = c; k.b = b;
    return k;
  endfunction

  // Receiver stall pattern: alternating stretches of free flow and random stalls.
  always @(posedge clk_i) begin
    cycle_count++;
    if (!receiver_stalls || (cycle_count % 512) < 128)
      out_ready_i <= 1'b1;
    else if ((cycle_count % 512) < 320)
      out_ready_i <= ($urandom_range(0, 3) != 0);
    else
      out_ready_i <= ($urandom_range(0, 3) == 0);
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d results outstanding", $realtime,
               pending_slopes.size());
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Compare each result item with the oldest expectation.
  always @(posedge clk_i) begin
    slope_item_t exp_item;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_slopes.size() == 0) begin
        errors++;
        $display("%0t: unexpected result arr=%h dep=%h st=%0d", $realtime,
                 arriving_slope_o, departing_slope_o, status_o);
      end else begin
        exp_item = pending_slopes.pop_front();
        checked_items++;
        if (arriving_slope_o !== exp_item.arr) begin
          errors++;
          $display("%0t: arriving_slope expected %h actual %h", $realtime,
                   exp_item.arr, arriving_slope_o);
        end
        if (departing_slope_o !== exp_item.dep) begin
          errors++;
          $display("%0t: departing_slope expected %h actual %h", $realtime,
                   exp_item.dep, departing_slope_o);
        end
        if (status_o !== exp_item.st) begin
          errors++;
          $display("%0t: status expected %0d actual %0d", $realtime,
                   exp_item.st, status_o);
        end
      end
    end
  end

  // Ordinary and extreme interior, first and last keys, plus the spare mode code.
  task automatic test_modes();
    send_key(make_key(MODE_INTERIOR, 0, 10, 30, 32'sd0, 32'sh10000, 32'sh30000,
                      16'sd0, 16'sd0, 16'sd0));
    send_key(make_key(MODE_FIRST, 5, 9, 40, -32'sh20000, 32'sh8000, 32'sh50000,
                      16'sd4096, -16'sd2000, 16'sd8000));
    send_key(make_key(MODE_LAST, 100, 200, 201, 32'sh7000, -32'sh1234, 32'sh2,
                      -16'sd16384, 16'sd16384, -16'sd16384));
    send_key(make_key(MODE_SPARE, 1, 2, 3, 32'sd5, 32'sd77, -32'sd99,
                      16'sd16384, -16'sd16384, 16'sd16384));
    send_key(make_key(MODE_INTERIOR, 0, 1, 65535, 32'sd1, -32'sd1, 32'sd1,
                      16'sd100, 16'sd16384, 16'sd16384));
    send_key(make_key(MODE_INTERIOR, 0, 65534, 65535, POS_MIN, POS_MAX, POS_MIN,
                      -16'sd16384, -16'sd16384, -16'sd16384));
  endtask

  // Saturation from extreme positions and out-of-range parameters.
  task automatic test_saturation();
    send_key(make_key(MODE_INTERIOR, 0, 1, 2, POS_MIN, POS_MAX, POS_MIN,
                      -16'sd16384, 16'sd0, 16'sd0));
    send_key(make_key(MODE_FIRST, 0, 65534, 65535, POS_MIN, POS_MAX, POS_MIN,
                      -16'sd32768, 16'sd0, 16'sd0));
    send_key(make_key(MODE_LAST, 0, 1, 65535, POS_MAX, POS_MIN, POS_MAX,
                      -16'sd32768, 16'sd0, 16'sd0));
    send_key(make_key(MODE_INTERIOR, 10, 11, 12, POS_MAX, POS_MIN, POS_MAX,
                      16'sh7fff, -16'sd32768, 16'sh7fff));
    send_key(make_key(MODE_INTERIOR, 10, 20, 30, POS_MAX, 32'sd0, POS_MIN,
                      -16'sd32768, -16'sd32768, -16'sd32768));
    send_key(make_key(MODE_FIRST, 3, 4, 6, 32'sd0, 32'sd0, 32'sd0,
                      16'sh7fff, 16'sh7fff, 16'sh7fff));
  endtask

  // Frames that are equal or out of order, in every mode.
  task automatic test_frame_order();
    send_key(make_key(MODE_INTERIOR, 5, 5, 9, 32'sd1, 32'sd2, 32'sd3,
                      16'sd0, 16'sd0, 16'sd0));
    send_key(make_key(MODE_FIRST, 5, 9, 9, 32'sd1, 32'sd2, 32'sd3,
                      16'sd0, 16'sd0, 16'sd0));
    send_key(make_key(MODE_LAST, 9, 5, 20, POS_MAX, POS_MIN, 32'sd3,
                      16'sd0, 16'sd0, 16'sd0));
    send_key(make_key(MODE_SPARE, 65535, 65535, 65535, 32'sd1, 32'sd2, 32'sd3,
                      16'sd0, 16'sd0, 16'sd0));
    send_key(make_key(MODE_INTERIOR, 0, 0, 0, 32'sd0, 32'sd0, 32'sd0,
                      16'sd0, 16'sd0, 16'sd0));
    send_key(make_key(MODE_FIRST, 30, 20, 10, 32'sd7, 32'sd8, 32'sd9,
                      16'sd0, 16'sd0, 16'sd0));
  endtask

  // Random keys: mostly increasing frames with in-range parameters, some noise.
  task automatic test_random(int unsigned count);
    key_item_t k;
    int unsigned sel, fa, fb, fc;
    for (int unsigned i = 0; i < count; i++) begin
      sel = $urandom_range(0, 9);
      k.mode = 2'($urandom_range(0, 3));
      if (sel < 4) begin
        fa = $urandom_range(0, 65000);
        fb = fa + $urandom_range(1, 250);
        fc = fb + $urandom_range(1, 250);
      end else if (sel < 8) begin
        fa = $urandom_range(0, 65533);
        fb = $urandom_range(fa + 1, 65534);
        fc = $urandom_range(fb + 1, 65535);
      end else begin
        fa = $urandom_range(0, 65535);
        fb = $urandom_range(0, 65535);
        fc = $urandom_range(0, 65535);
      end
      k.fa = FRAME_BITS'(fa); k.fb = FRAME_BITS'(fb); k.fc = FRAME_BITS'(fc);
      if ($urandom_range(0, 2) == 0) begin
        k.pa = $urandom;
        k.pb = $urandom;
        k.pc = $urandom;
      end else begin
        k.pa = $signed(32'($urandom_range(0, 32'h1FFFFF))) - 32'sh100000;
        k.pb = k.pa + $signed(32'($urandom_range(0, 32'h3FFFF))) - 32'sh20000;
        k.pc = k.pb + $signed(32'($urandom_range(0, 32'h3FFFF))) - 32'sh20000;
      end
      if ($urandom_range(0, 9) == 0) begin
        k.t = PAR_BITS'($urandom);
        k.c = PAR_BITS'($urandom);
        k.b = PAR_BITS'($urandom);
      end else begin
        k.t = $signed(16'($urandom_range(0, 32768))) - 16'sd16384;
        k.c = $signed(16'($urandom_range(0, 32768))) - 16'sd16384;
        k.b = $signed(16'($urandom_range(0, 32768))) - 16'sd16384;
      end
      send_key(k);
    end
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_modes();
    test_saturation();
    test_frame_order();
    // A stretch with no idling on either side, then the usual pattern.
    sender_idles = 1'b0;
    receiver_stalls = 1'b0;
    test_random(300);
    sender_idles = 1'b1;
    receiver_stalls = 1'b1;
    test_random(1400);
    in_valid_i <= 1'b0;
    while (pending_slopes.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    $display("Covered %0d key items over all modes, saturation and frame order cases;",
             sent_items);
    $display("%0d results compared, %0d mismatches.", checked_items, errors);
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
